// ----- src/csv_tok_pkg.sv -----
// Package for the CSV field tokenizer: shared constants, register codes and
// the structs passed between the tokenizer modules. No dependencies.
package csv_tok_pkg;

	// Stream limits
	localparam int unsigned MAX_COLUMNS = 255;
	localparam int unsigned MAX_ROWS    = 65535;

	localparam int COL_W = 8;
	localparam int ROW_W = 16;

	// Highest column index and row index the counters reach
	localparam logic [COL_W-1:0] COL_SAT =
		COL_W'((MAX_COLUMNS - 1 < 255) ? MAX_COLUMNS - 1 : 255);
	localparam logic [ROW_W-1:0] ROW_SAT =
		ROW_W'((MAX_ROWS - 1 < 65535) ? MAX_ROWS - 1 : 65535);
	// Field count of one row is clamped here
	localparam logic [COL_W:0] WIDTH_SAT =
		(COL_W+1)'((MAX_COLUMNS < 255) ? MAX_COLUMNS : 255);

	localparam logic [7:0] QUOTE_CHAR        = 8'h22;
	localparam logic [7:0] DEFAULT_FIELD_SEP = 8'h2C;
	localparam logic [7:0] DEFAULT_ROW_SEP   = 8'h0A;

	// Register map, index = paddr[2]
	localparam int APB_ADDR_W = 3;
	localparam logic REG_FIELD_SEP = 1'b0;
	localparam logic REG_ROW_SEP   = 1'b1;

	typedef struct packed {
		logic [7:0] field_sep;
		logic [7:0] row_sep;
	} cfg_t;

	typedef struct packed {
		logic             has_result;
		logic             char_valid;
		logic [7:0]       out_char;
		logic [COL_W-1:0] column_index;
		logic [ROW_W-1:0] row_index;
		logic             field_end;
		logic             row_end;
		logic [COL_W-1:0] widest_row;
	} result_t;

endpackage

// ----- src/csv_tok_cfg.sv -----
// APB-style register block holding the field and row separators.
// Depends on csv_tok_pkg.
module csv_tok_cfg
	import csv_tok_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [7:0] field_sep_q;
	logic [7:0] row_sep_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_sep_q <= DEFAULT_FIELD_SEP;
			row_sep_q   <= DEFAULT_ROW_SEP;
		end else if (wr_en) begin
			case (paddr[2])
				REG_FIELD_SEP: field_sep_q <= pwdata[7:0];
				REG_ROW_SEP:   row_sep_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (paddr[2])
			REG_FIELD_SEP: prdata = {24'd0, field_sep_q};
			REG_ROW_SEP:   prdata = {24'd0, row_sep_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign cfg.field_sep = field_sep_q;
	assign cfg.row_sep   = row_sep_q;

endmodule

// ----- src/csv_tok_core.sv -----
// Tokenizer state and per-byte next-state logic: quote handling, field and
// row counting, widest-row tracking. Depends on csv_tok_pkg.
module csv_tok_core
	import csv_tok_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] in_byte,
	input  logic       last,
	input  cfg_t       cfg,
	output result_t    res
);

	logic             row_open_q, field_start_q, quoted_q, qpend_q;
	logic [COL_W-1:0] col_q, max_col_q;
	logic [ROW_W-1:0] row_q;

	logic             row_open_d, field_start_d, quoted_d, qpend_d;
	logic [COL_W-1:0] col_d, max_col_d;
	logic [ROW_W-1:0] row_d;

	logic             is_rsep, raw, cv, fe, re;
	logic [COL_W:0]   width;

	// per-byte decode and next state
	always_comb begin
		row_open_d    = row_open_q;
		field_start_d = field_start_q;
		quoted_d      = quoted_q;
		qpend_d       = qpend_q;
		col_d         = col_q;
		max_col_d     = max_col_q;
		row_d         = row_q;
		cv            = 1'b0;
		fe            = 1'b0;
		re            = 1'b0;
		raw           = 1'b1;
		width         = '0;
		is_rsep       = (in_byte == cfg.row_sep);

		res.has_result   = 1'b1;
		res.column_index = col_q;
		res.row_index    = row_q;

		if (is_rsep) begin
			// row separator: closes an open row; an empty line has nothing to report
			res.has_result = row_open_q;
			fe = row_open_q;
			re = row_open_q;
		end else begin
			row_open_d = 1'b1;
			// inside a quoted field
			if (quoted_q) begin
				raw = 1'b0;
				if (qpend_q) begin
					qpend_d = 1'b0;
					if (in_byte == QUOTE_CHAR) begin
						cv = 1'b1;
					end else begin
						quoted_d = 1'b0;
						raw = 1'b1;
					end
				end else if (in_byte == QUOTE_CHAR) begin
					qpend_d = 1'b1;
				end else begin
					cv = 1'b1;
				end
			end
			// plain text, opening quote or field separator
			if (raw) begin
				if (field_start_q && in_byte == QUOTE_CHAR) begin
					quoted_d      = 1'b1;
					field_start_d = 1'b0;
				end else if (in_byte == cfg.field_sep) begin
					fe = 1'b1;
					if (col_q < COL_SAT)
						col_d = col_q + 1'b1;
					field_start_d = 1'b1;
				end else begin
					cv = 1'b1;
					field_start_d = 1'b0;
				end
			end
			if (last) begin
				fe = 1'b1;
				re = 1'b1;
			end
		end

		// row close: width update, row count, column reset
		if (re) begin
			width = {1'b0, col_d} + 1'b1;
			if (width > WIDTH_SAT)
				width = WIDTH_SAT;
			if (width[COL_W-1:0] > max_col_q)
				max_col_d = width[COL_W-1:0];
			if (row_q < ROW_SAT)
				row_d = row_q + 1'b1;
			col_d         = '0;
			field_start_d = 1'b1;
			quoted_d      = 1'b0;
			qpend_d       = 1'b0;
			row_open_d    = 1'b0;
		end

		res.char_valid = cv;
		res.out_char   = cv ? in_byte : 8'd0;
		res.field_end  = fe;
		res.row_end    = re;
		res.widest_row = max_col_d;

		// end of stream: back to the reset state
		if (last) begin
			row_open_d    = 1'b0;
			field_start_d = 1'b1;
			quoted_d      = 1'b0;
			qpend_d       = 1'b0;
			col_d         = '0;
			row_d         = '0;
			max_col_d     = '0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_open_q    <= 1'b0;
			field_start_q <= 1'b1;
			quoted_q      <= 1'b0;
			qpend_q       <= 1'b0;
			col_q         <= '0;
			row_q         <= '0;
			max_col_q     <= '0;
		end else if (step) begin
			row_open_q    <= row_open_d;
			field_start_q <= field_start_d;
			quoted_q      <= quoted_d;
			qpend_q       <= qpend_d;
			col_q         <= col_d;
			row_q         <= row_d;
			max_col_q     <= max_col_d;
		end
	end

	// a pending quote only exists inside a quoted field
	a_qpend_quoted: assert property (@(posedge clk) disable iff (!arst_n)
		qpend_q |-> quoted_q)
		else $error("quote pending outside quoted field");

	// a quoted field has already consumed its first byte
	a_quoted_not_start: assert property (@(posedge clk) disable iff (!arst_n)
		quoted_q |-> !field_start_q)
		else $error("quoted field still marked at field start");

	// columns only advance within an open row
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		!row_open_q |-> (col_q == '0))
		else $error("column count nonzero with no open row");

endmodule

// ----- src/csv_field_tokenizer.sv -----
// Top level of the CSV field tokenizer: input stage, result register and
// the register block. Depends on csv_tok_pkg, csv_tok_cfg, csv_tok_core.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   in      | in_valid, in_ready, in_byte, last         | in
//   out     | out_valid, out_ready, char_valid, out_char,| out
//           | column_index, row_index, field_end,       |
//           | row_end, widest_row                       |
//   apb     | psel, penable, pwrite, paddr, pwdata,     | in
//           | prdata, pready                            |
//
// One byte per cycle sustained while out_ready holds; an accepted byte passes
// the input stage, then the tokenizer logic, into the result register,
// from which its result is offered.
// Bytes that give no result (empty lines) pass through without output.
// A stalled result register holds the input stage; the input stage still
// takes a byte while the result waits, if it is empty.
// Reset clears the tokenizer state and sets separators to ',' and newline.
module csv_field_tokenizer
	import csv_tok_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  char_valid,
	output logic [7:0]            out_char,
	output logic [COL_W-1:0]      column_index,
	output logic [ROW_W-1:0]      row_index,
	output logic                  field_end,
	output logic                  row_end,
	output logic [COL_W-1:0]      widest_row,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cfg_t       cfg;
	result_t    res;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	logic       out_valid_q;
	result_t    out_q;

	csv_tok_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// stage 1 moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= last;
		end
	end

	csv_tok_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.in_byte(byte_s1),
		.last   (last_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.has_result;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.has_result)
			out_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign char_valid   = out_q.char_valid;
	assign out_char     = out_q.out_char;
	assign column_index = out_q.column_index;
	assign row_index    = out_q.row_index;
	assign field_end    = out_q.field_end;
	assign row_end      = out_q.row_end;
	assign widest_row   = out_q.widest_row;

	// a closed row always closes its field
	a_row_closes_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_q.row_end || out_q.field_end))
		else $error("row end without field end");

	// a consumed byte carries no character
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.char_valid) |-> (out_q.out_char == 8'd0))
		else $error("character set on a result with no character");

	// stage 1 keeps its byte while the result register is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input stage dropped a byte while stalled");

endmodule
